### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request and
// response payloads, command codes, character codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  // reset attribute: white on black
  localparam logic [7:0] COLOR_RESET = 8'd15;

  // one cell in memory: attribute in the high byte, character in the low byte
  localparam int CELL_W = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       scrolled;
  } tcw_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_PUT,
    ST_RESP
  } tcw_state_t;

endpackage

`default_nettype wire

### src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text screen with a cursor, kept in one cell memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_req carry one request: put a character (newline
//   moves down a row, scrolling at the bottom), clear the screen, or read
//   one cell. Every request gives exactly one response on out_valid/
//   out_ready/out_rsp with the cursor after the request and, for a read,
//   the cell contents. cfg_we/cfg_wdata set the attribute byte used for
//   written and blanked cells; write it only while the block is idle.
//   A newline or a wrap on the bottom row scrolls: rows move up one and the
//   last row is blanked; a clear blanks every cell.
//   One request is worked at a time; the next is taken once the response is
//   parked in the output register, even while the receiver stalls. A stall
//   holds the response register and delays the next response only.
//   Reset puts the cursor at row 0, column 0 and the attribute at 0x0f;
//   the cell memory is not cleared, so issue a clear before reading cells.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tcw_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output tcw_rsp_t      out_rsp,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int NCells = COLS * ROWS;
  localparam int AddrW  = $clog2(NCells);
  localparam int RowW   = $clog2(ROWS);
  localparam int ColW   = $clog2(COLS + 1);

  localparam logic [AddrW-1:0] LastCopy    = AddrW'(NCells - COLS - 1);
  localparam logic [AddrW-1:0] LastRowBase = AddrW'(NCells - COLS);
  localparam logic [AddrW-1:0] LastCell    = AddrW'(NCells - 1);
  localparam logic [RowW-1:0]  LastRow     = RowW'(ROWS - 1);
  localparam logic [ColW-1:0]  FullCol     = ColW'(COLS);

  tcw_state_t        state_r, state_nxt;
  logic [RowW-1:0]   cur_row_r, cur_row_nxt;
  logic [ColW-1:0]   cur_col_r, cur_col_nxt;
  logic [7:0]        color_r, color_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [AddrW-1:0]  cnt_r, cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AddrW-1:0]  wr_addr_r, wr_addr_nxt;
  logic              put_pend_r, put_pend_nxt;
  logic              scr_r, scr_nxt;
  logic [7:0]        rc_r, rc_nxt;
  logic [7:0]        rcol_r, rcol_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_rsp_t          out_rsp_r, out_rsp_nxt;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              accept;
  logic              is_nl;
  logic              at_last_row;
  logic              line_full;
  logic              idx_ok;
  logic              slot_free;
  logic [31:0]       idx32;
  logic [31:0]       put_addr32;
  logic [31:0]       src_addr32;
  logic [31:0]       row32;
  logic [31:0]       col32;

  // cell memory
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCells)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode helpers
  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign is_nl       = (in_req.char_code == NEWLINE_CODE);
  assign at_last_row = (cur_row_r == LastRow);
  assign line_full   = (cur_col_r == FullCol);
  assign idx32       = 32'(in_req.cell_index);
  assign idx_ok      = (idx32 < 32'(NCells));
  assign slot_free   = !out_valid_r || out_ready;
  assign row32       = 32'(cur_row_r);
  assign col32       = 32'(cur_col_r);
  assign put_addr32  = row32 * 32'(COLS) + col32;
  assign src_addr32  = 32'(cnt_r) + 32'(COLS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_req.cmd)
            CMD_PUT: begin
              if (is_nl) begin
                state_nxt = at_last_row ? ST_SCROLL : ST_RESP;
              end else if (line_full && at_last_row) begin
                state_nxt = ST_SCROLL;
              end else begin
                state_nxt = ST_PUT;
              end
            end
            CMD_CLEAR: state_nxt = ST_FILL;
            CMD_READ:  state_nxt = idx_ok ? ST_RD_WAIT : ST_RESP;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_RESP;
      ST_SCROLL: begin
        if (cnt_r == LastCopy) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FILL;
      ST_FILL: begin
        if (cnt_r == LastCell) begin
          state_nxt = put_pend_r ? ST_PUT : ST_RESP;
        end
      end
      ST_PUT: state_nxt = ST_RESP;
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory control and response
  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    color_nxt     = cfg_we ? cfg_wdata : color_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    put_pend_nxt  = put_pend_r;
    scr_nxt       = scr_r;
    rc_nxt        = rc_r;
    rcol_nxt      = rcol_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_addr_r;
    ram_wdata     = ram_rdata;

    // copy write, in the cycle after its read
    if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ch_nxt       = in_req.char_code;
          scr_nxt      = 1'b0;
          rc_nxt       = '0;
          rcol_nxt     = '0;
          put_pend_nxt = 1'b0;
          cnt_nxt      = '0;
          unique case (in_req.cmd)
            CMD_PUT: begin
              // newline, or wrap before a printable byte
              if (is_nl || line_full) begin
                cur_col_nxt = '0;
                if (at_last_row) begin
                  scr_nxt      = 1'b1;
                  put_pend_nxt = !is_nl;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                ram_re    = 1'b1;
                ram_raddr = idx32[AddrW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        rc_nxt   = ram_rdata[7:0];
        rcol_nxt = ram_rdata[15:8];
      end
      ST_SCROLL: begin
        // read one row down, write here next cycle
        ram_re      = 1'b1;
        ram_raddr   = src_addr32[AddrW-1:0];
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = cnt_r;
        cnt_nxt     = cnt_r + 1'b1;
      end
      ST_DRAIN: begin
        cnt_nxt = LastRowBase;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {color_r, SPACE_CODE};
        cnt_nxt   = cnt_r + 1'b1;
      end
      ST_PUT: begin
        ram_we       = 1'b1;
        ram_waddr    = put_addr32[AddrW-1:0];
        ram_wdata    = {color_r, ch_r};
        cur_col_nxt  = cur_col_r + 1'b1;
        put_pend_nxt = 1'b0;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.cursor_row = row32[4:0];
          out_rsp_nxt.cursor_col = col32[6:0];
          out_rsp_nxt.cell_char  = rc_r;
          out_rsp_nxt.cell_color = rcol_r;
          out_rsp_nxt.scrolled   = scr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      color_r     <= COLOR_RESET;
      wr_pend_r   <= 1'b0;
      put_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      color_r     <= color_nxt;
      wr_pend_r   <= wr_pend_nxt;
      put_pend_r  <= put_pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    wr_addr_r <= wr_addr_nxt;
    scr_r     <= scr_nxt;
    rc_r      <= rc_nxt;
    rcol_r    <= rcol_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // cursor row stays on the screen; the column may reach COLS at line end
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < 32'(ROWS))
    else $error("cursor row beyond last row");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) <= 32'(COLS))
    else $error("cursor column beyond line end");

  // scroll copy never reads the cell it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("cell memory read and write collide");

  // a request is taken only with no copy write or pending put in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!wr_pend_r && !put_pend_r))
    else $error("request taken during a screen sweep");

endmodule

`default_nettype wire
